// File: design/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared types, codes and helpers for the Bloom filter insert/query block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int unsigned FILTER_SIZE_DEF = 65536;
  localparam int unsigned MAX_HASHES_DEF  = 8;

  // Fixed field widths.
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned NUM_HASH = 8;
  localparam int unsigned HIDX_W   = 3;
  localparam int unsigned NH_W     = 4;
  localparam int unsigned FB_W     = 17;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned BCNT_W   = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Register reset values.
  localparam logic [NH_W-1:0] NUM_HASHES_RST  = 4'd4;
  localparam logic [FB_W-1:0] FILTER_BITS_RST = 17'h10000;

  // Saturation limit of the set-bit counter.
  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 2'd1;

  // Operation codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              func;
    logic [HASH_W-1:0] hash_0;
    logic [HASH_W-1:0] hash_1;
    logic [HASH_W-1:0] hash_2;
    logic [HASH_W-1:0] hash_3;
    logic [HASH_W-1:0] hash_4;
    logic [HASH_W-1:0] hash_5;
    logic [HASH_W-1:0] hash_6;
    logic [HASH_W-1:0] hash_7;
  } req_t;

  typedef struct packed {
    logic             is_member;
    logic [CNT_W-1:0] bits_set;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic capture;
    logic load_div;
    logic div_step;
    logic mem_rd;
    logic check;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic hash_last;
    logic out_free;
  } sts_t;

  function automatic logic [HASH_W-1:0] pick_hash(req_t r, logic [HIDX_W-1:0] i);
    logic [HASH_W-1:0] h;
    case (i)
      3'd0:    h = r.hash_0;
      3'd1:    h = r.hash_1;
      3'd2:    h = r.hash_2;
      3'd3:    h = r.hash_3;
      3'd4:    h = r.hash_4;
      3'd5:    h = r.hash_5;
      3'd6:    h = r.hash_6;
      default: h = r.hash_7;
    endcase
    return h;
  endfunction

endpackage

// File: design/bfiq_ctrl.sv
// ----------------------------------------------------------------------------
// Bloom filter controller
// State machine that sequences the clearing pass and the per-hash work.
// ----------------------------------------------------------------------------
module bfiq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  bfiq_pkg::sts_t  sts_i,
  output bfiq_pkg::cmd_t  cmd_o
);

  bfiq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfiq_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfiq_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = bfiq_pkg::ST_IDLE;
      end
      bfiq_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = bfiq_pkg::ST_LOAD;
      end
      bfiq_pkg::ST_LOAD: begin
        state_d = bfiq_pkg::ST_DIV;
      end
      bfiq_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = bfiq_pkg::ST_READ;
      end
      bfiq_pkg::ST_READ: begin
        state_d = bfiq_pkg::ST_CHECK;
      end
      bfiq_pkg::ST_CHECK: begin
        state_d = sts_i.hash_last ? bfiq_pkg::ST_DONE : bfiq_pkg::ST_LOAD;
      end
      bfiq_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = bfiq_pkg::ST_IDLE;
      end
      default: begin
        state_d = bfiq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      bfiq_pkg::ST_CLEAR: cmd_o.clr_en = 1'b1;
      bfiq_pkg::ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      bfiq_pkg::ST_LOAD:  cmd_o.load_div = 1'b1;
      bfiq_pkg::ST_DIV:   cmd_o.div_step = 1'b1;
      bfiq_pkg::ST_READ:  cmd_o.mem_rd   = 1'b1;
      bfiq_pkg::ST_CHECK: cmd_o.check    = 1'b1;
      bfiq_pkg::ST_DONE:  cmd_o.out_load = sts_i.out_free;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: design/bfiq_dp.sv
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Configuration registers, bit-serial modulo unit, bit store, set-bit
// counter and result register.
// ----------------------------------------------------------------------------
module bfiq_dp #(
  parameter int unsigned FILTER_SIZE = bfiq_pkg::FILTER_SIZE_DEF,
  parameter int unsigned MAX_HASHES  = bfiq_pkg::MAX_HASHES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  bfiq_pkg::req_t                      req_i,
  output bfiq_pkg::rsp_t                      rsp_o,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  input  bfiq_pkg::cmd_t                      cmd_i,
  output bfiq_pkg::sts_t                      sts_o
);

  localparam int unsigned AW = $clog2(FILTER_SIZE);
  localparam int unsigned RW = (AW > bfiq_pkg::FB_W) ? AW : bfiq_pkg::FB_W;
  localparam int unsigned SW = ($clog2(FILTER_SIZE + 1) > bfiq_pkg::FB_W) ?
                               $clog2(FILTER_SIZE + 1) : bfiq_pkg::FB_W;
  localparam logic [SW-1:0] FS_MAX   = SW'(FILTER_SIZE);
  localparam logic [AW-1:0] CLR_LAST = AW'(FILTER_SIZE - 1);
  localparam logic [bfiq_pkg::NH_W-1:0] K_MAX = bfiq_pkg::NH_W'(MAX_HASHES);

  // Configuration registers.
  logic [bfiq_pkg::NH_W-1:0] nh_q;
  logic [bfiq_pkg::FB_W-1:0] fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nh_q <= bfiq_pkg::NUM_HASHES_RST;
      fb_q <= bfiq_pkg::FILTER_BITS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bfiq_pkg::CFG_NUM_HASHES) begin
        nh_q <= cfg_data_i[bfiq_pkg::NH_W-1:0];
      end else if (cfg_idx_i == bfiq_pkg::CFG_FILTER_BITS) begin
        fb_q <= cfg_data_i[bfiq_pkg::FB_W-1:0];
      end
    end
  end

  // Effective hash count and divisor after clamping.
  logic [bfiq_pkg::NH_W-1:0] eff_k;
  logic [SW-1:0]             fb_ext;
  logic [SW-1:0]             size_w;
  logic [bfiq_pkg::FB_W-1:0] size;

  always_comb begin
    if (nh_q == '0) begin
      eff_k = bfiq_pkg::NH_W'(1);
    end else if (nh_q > K_MAX) begin
      eff_k = K_MAX;
    end else begin
      eff_k = nh_q;
    end
    fb_ext = SW'(fb_q);
    if (fb_q == '0) begin
      size_w = SW'(1);
    end else if (fb_ext > FS_MAX) begin
      size_w = FS_MAX;
    end else begin
      size_w = fb_ext;
    end
    // The clamped size always fits the 17-bit register width.
    size = size_w[bfiq_pkg::FB_W-1:0];
  end

  // Captured request and per-item progress.
  bfiq_pkg::req_t                req_q;
  logic [bfiq_pkg::HIDX_W-1:0]   hidx_q;
  logic                          member_q;

  // Restoring divider, one quotient bit per cycle.
  logic [bfiq_pkg::HASH_W-1:0]   dvd_q;
  logic [bfiq_pkg::FB_W-1:0]     rem_q;
  logic [bfiq_pkg::BCNT_W-1:0]   bcnt_q;
  logic [bfiq_pkg::FB_W:0]       trial;
  logic [bfiq_pkg::FB_W:0]       diff;

  assign trial = {rem_q, dvd_q[bfiq_pkg::HASH_W-1]};
  assign diff  = trial - {1'b0, size};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.load_div) begin
      dvd_q  <= bfiq_pkg::pick_hash(req_q, hidx_q);
      rem_q  <= '0;
      bcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[bfiq_pkg::HASH_W-2:0], 1'b0};
      bcnt_q <= bcnt_q + bfiq_pkg::BCNT_W'(1);
      if (trial >= {1'b0, size}) begin
        rem_q <= diff[bfiq_pkg::FB_W-1:0];
      end else begin
        rem_q <= trial[bfiq_pkg::FB_W-1:0];
      end
    end
  end

  // Remainder is below the size, so it always fits the store address.
  logic [RW-1:0] rem_ext;
  logic [AW-1:0] rem_addr;

  assign rem_ext  = RW'(rem_q);
  assign rem_addr = rem_ext[AW-1:0];

  // Bit store with registered read.
  logic            mem [FILTER_SIZE];
  logic            rd_q;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   clr_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic            mem_wd;
  logic            set_new;

  assign set_new = cmd_i.check && (req_q.func == bfiq_pkg::FUNC_ADD) && !rd_q;

  always_comb begin
    if (cmd_i.clr_en) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = 1'b0;
    end else begin
      mem_we = set_new;
      mem_wa = addr_q;
      mem_wd = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.mem_rd) begin
      rd_q   <= mem[rem_addr];
      addr_q <= rem_addr;
    end
  end

  // Control registers: clear sweep, hash index, membership, count, result.
  logic [bfiq_pkg::CNT_W-1:0] cnt_q;
  logic                       rsp_valid_q;
  bfiq_pkg::rsp_t             rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      hidx_q      <= '0;
      member_q    <= 1'b1;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.capture) begin
        hidx_q   <= '0;
        member_q <= 1'b1;
      end else if (cmd_i.check) begin
        hidx_q <= hidx_q + bfiq_pkg::HIDX_W'(1);
        if (!rd_q) begin
          member_q <= 1'b0;
        end
      end
      if (set_new && (cnt_q != bfiq_pkg::CNT_MAX)) begin
        cnt_q <= cnt_q + bfiq_pkg::CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.is_member <= (req_q.func == bfiq_pkg::FUNC_QUERY) && member_q;
      rsp_q.bits_set  <= cnt_q;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  assign sts_o.clr_last  = (clr_q == CLR_LAST);
  assign sts_o.div_last  = (bcnt_q == bfiq_pkg::BCNT_W'(bfiq_pkg::HASH_W - 1));
  assign sts_o.hash_last = ({1'b0, hidx_q} == (eff_k - bfiq_pkg::NH_W'(1)));
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

endmodule

// File: design/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// Bloom filter insert/query block
// Adds items to, or tests items against, a single-bit store picked by hashes.
// ----------------------------------------------------------------------------
// Each request carries func (add or query) and eight 64-bit hash values; the
// first k of them are reduced modulo the clamped filter_bits, and each remainder
// picks one bit of the store. An add sets those bits, a query reports
// is_member when all of them are set. Every request gives one response with
// the membership flag and the number of set bits in the store after it.
// Both channels use valid/ready; configuration is a plain write port that
// should only be used while the block is idle.
// Here k is num_hashes clamped to 1..MAX_HASHES, and filter_bits is clamped
// to 1..FILTER_SIZE. Each hash is loaded into the one-bit-per-cycle modulo
// unit and reduced, then the store is read through its registered port and
// the bit is checked and, for an add, set.
// Only one request is worked on at a time: the next request is not taken until
// the last one is through; a new request is accepted while a finished response
// still waits in the output register.
// After reset the store is swept clear, one bit per cycle, over all FILTER_SIZE
// bits before the first request is accepted; configuration writes are taken
// throughout. If the receiver stalls, the finished response holds and the
// block waits with the next result until the output register frees up.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
  parameter int unsigned FILTER_SIZE = bfiq_pkg::FILTER_SIZE_DEF,
  parameter int unsigned MAX_HASHES  = bfiq_pkg::MAX_HASHES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  bfiq_pkg::req_t                   req_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output bfiq_pkg::rsp_t                   rsp_o
);

  // Commands and status between the sequencer and the datapath.
  bfiq_pkg::cmd_t cmd;
  bfiq_pkg::sts_t sts;

  bfiq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfiq_dp #(
    .FILTER_SIZE (FILTER_SIZE),
    .MAX_HASHES  (MAX_HASHES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
